// File: design/pmp_pkg.sv
// shared types, constants and the lane max function for the padded max pool window update block
`default_nettype none
package pmp_pkg;

    localparam int OUT_DEPTH  = 1024;
    localparam int ADDR_W     = $clog2(OUT_DEPTH);
    localparam int RES_ADDR_W = 10;
    localparam int WORD_W     = 64;
    localparam int NUM_WORDS  = 4;
    localparam int LINE_W     = WORD_W * NUM_WORDS;
    localparam int LANES      = WORD_W / 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int SUM_W      = 20;
    localparam int COORD_W    = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    // front register, queue, read stage, output register
    localparam int PIPE_CAP   = QUEUE_DEPTH + 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRIDE    = 3'd0,
        CFG_PAD       = 3'd1,
        CFG_IN_HEIGHT = 3'd2,
        CFG_IN_WIDTH  = 3'd3,
        CFG_OUT_W8    = 3'd4
    } cfg_idx_e;

    typedef struct packed {
        logic [3:0]  stride;
        logic [3:0]  pad;
        logic [10:0] in_height;
        logic [10:0] in_width;
        logic [10:0] out_width_align8;
    } cfg_t;

    typedef struct packed {
        logic [9:0]        out_row;
        logic [7:0]        depth_tile;
        logic [9:0]        out_col;
        logic [3:0]        win_row;
        logic [3:0]        win_col;
        logic [WORD_W-1:0] bank0_low;
        logic [WORD_W-1:0] bank0_high;
        logic [WORD_W-1:0] bank1_low;
        logic [WORD_W-1:0] bank1_high;
    } in_item_t;

    typedef struct packed {
        logic [RES_ADDR_W-1:0] result_addr;
        logic [WORD_W-1:0]     max0_low;
        logic [WORD_W-1:0]     max0_high;
        logic [WORD_W-1:0]     max1_low;
        logic [WORD_W-1:0]     max1_high;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              first;
        logic [LINE_W-1:0] tap;
    } tap_entry_t;

    function automatic logic [WORD_W-1:0] lane_max(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int k = 0; k < LANES; k++) begin
            if ($signed(a[k*8 +: 8]) > $signed(b[k*8 +: 8])) begin
                r[k*8 +: 8] = a[k*8 +: 8];
            end else begin
                r[k*8 +: 8] = b[k*8 +: 8];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/pmp_front.sv
// front stage: window coordinates, bounds check, store address
`default_nettype none
module pmp_front
    import pmp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,
    output logic            push_valid,
    input  wire logic       push_ready,
    output tap_entry_t      push_entry
);

    logic              valid_reg;
    tap_entry_t        entry_reg;
    tap_entry_t        entry_next;
    logic [COORD_W-1:0] row_prod;
    logic [COORD_W-1:0] col_prod;
    logic signed [COORD_W-1:0] row;
    logic signed [COORD_W-1:0] col;
    logic              in_map;
    logic [SUM_W-1:0]  sum;

    always_comb begin
        row_prod = COORD_W'({6'b0, s_data.out_row} * {12'b0, cfg.stride});
        col_prod = COORD_W'({6'b0, s_data.out_col} * {12'b0, cfg.stride});
        row = $signed(row_prod) - $signed({12'b0, cfg.pad}) + $signed({12'b0, s_data.win_row});
        col = $signed(col_prod) - $signed({12'b0, cfg.pad}) + $signed({12'b0, s_data.win_col});
        in_map = !row[COORD_W-1] && (row < $signed({5'b0, cfg.in_height})) &&
                 !col[COORD_W-1] && (col < $signed({5'b0, cfg.in_width}));
        sum = SUM_W'({12'b0, s_data.depth_tile} * {9'b0, cfg.out_width_align8})
            + SUM_W'({10'b0, s_data.out_col});
        entry_next.addr  = sum[ADDR_W-1:0];
        entry_next.first = (s_data.win_row == 4'd0) && (s_data.win_col == 4'd0);
        entry_next.tap   = in_map ? {s_data.bank0_low, s_data.bank0_high,
                                     s_data.bank1_low, s_data.bank1_high} : '0;
    end

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            entry_reg <= entry_next;
        end
    end

endmodule
`default_nettype wire

// File: design/pmp_queue.sv
// small request queue between front and back stages
`default_nettype none
module pmp_queue
    import pmp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  wire tap_entry_t push_entry,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output tap_entry_t      pop_entry
);

    tap_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// File: design/pmp_back.sv
// back stage: running max read, lane max, write back and result register
`default_nettype none
module pmp_back
    import pmp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       pop_valid,
    output logic            pop_ready,
    input  wire tap_entry_t pop_entry,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data
);

    logic [LINE_W-1:0] mem [OUT_DEPTH];

    logic              b_valid_reg;
    tap_entry_t        b_entry_reg;
    logic [LINE_W-1:0] rd_data_reg;
    logic              fwd_hit_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic              b_fire;
    logic              do_pop;
    logic [LINE_W-1:0] prev;
    logic [LINE_W-1:0] result;
    logic [ADDR_W+RES_ADDR_W-1:0] addr_ext;

    assign b_fire    = b_valid_reg && (!m_valid_reg || m_ready);
    assign pop_ready = !b_valid_reg || b_fire;
    assign do_pop    = pop_valid && pop_ready;

    always_comb begin
        if (b_entry_reg.first) begin
            prev = '0;
        end else if (fwd_hit_reg) begin
            prev = fwd_data_reg;
        end else begin
            prev = rd_data_reg;
        end
        for (int w = 0; w < NUM_WORDS; w++) begin
            result[w*WORD_W +: WORD_W] = lane_max(b_entry_reg.tap[w*WORD_W +: WORD_W],
                                                  prev[w*WORD_W +: WORD_W]);
        end
        addr_ext = {{RES_ADDR_W{1'b0}}, b_entry_reg.addr};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop_ready) begin
                b_valid_reg <= pop_valid;
            end
            if (b_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // read issued in the same cycle as a write to the same line sees old data
    always_ff @(posedge aclk) begin
        if (do_pop) begin
            b_entry_reg  <= pop_entry;
            rd_data_reg  <= mem[pop_entry.addr];
            fwd_hit_reg  <= b_fire && (b_entry_reg.addr == pop_entry.addr);
            fwd_data_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire) begin
            mem[b_entry_reg.addr] <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire) begin
            m_data_reg.result_addr <= addr_ext[RES_ADDR_W-1:0];
            m_data_reg.max0_low    <= result[3*WORD_W +: WORD_W];
            m_data_reg.max0_high   <= result[2*WORD_W +: WORD_W];
            m_data_reg.max1_low    <= result[1*WORD_W +: WORD_W];
            m_data_reg.max1_high   <= result[0 +: WORD_W];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// File: design/padded_max_pool_window_update.sv
// top level of the padded int8 max pool window update block
// Each request is one pooling-window tap of 32 signed int8 lanes; the block takes one request
// per cycle unless the result side stalls, and returns the updated running maxima after the
// front register loaded at acceptance, a queue slot, the store read and the result register.
// The running-max store is a 1024-line by 256-bit memory with one read and one write port;
// back-to-back taps on the same line are forwarded so the sustained rate stays at one request
// per cycle when nothing stalls. Store lines hold no defined value until the first tap of a
// window writes them. Up to seven requests may be in flight. The user must write configuration
// through the cfg channel only while no request is pending; the block itself does not enforce this.
`default_nettype none
module padded_max_pool_window_update
    import pmp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    logic       push_valid;
    logic       push_ready;
    tap_entry_t push_entry;
    logic       pop_valid;
    logic       pop_ready;
    tap_entry_t pop_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stride           <= 4'd1;
            cfg_reg.pad              <= 4'd0;
            cfg_reg.in_height        <= 11'd1;
            cfg_reg.in_width         <= 11'd1;
            cfg_reg.out_width_align8 <= 11'd8;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_e'(cfg_index))
                CFG_STRIDE:    cfg_reg.stride           <= cfg_data[3:0];
                CFG_PAD:       cfg_reg.pad              <= cfg_data[3:0];
                CFG_IN_HEIGHT: cfg_reg.in_height        <= cfg_data;
                CFG_IN_WIDTH:  cfg_reg.in_width         <= cfg_data;
                CFG_OUT_W8:    cfg_reg.out_width_align8 <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    pmp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    pmp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    pmp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

// File: design/pmp_checker.sv
// port-level checker for the padded max pool window update block and its bind
`default_nettype none
module pmp_checker
    import pmp_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    logic [3:0] pending_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 4'(s_valid && s_ready) - 4'(m_valid && m_ready);
        end
    end

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result payload changed while stalled");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 4'd0)
        else $error("result without a pending request");

    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg >= 4'(PIPE_CAP) |-> !s_ready)
        else $error("request taken beyond pipeline capacity");

endmodule

bind padded_max_pool_window_update pmp_checker u_pmp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

// File: dv/tb_top.sv
// self-checking testbench for the padded int8 max pool window update block
`timescale 1ns / 1ps
module tb_top;
    import pmp_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 5;
    localparam int PHASE_TAPS    = 48;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_STEP     = 180;
    localparam int MAX_HOLDS     = 2;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_CAP    = 40;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_BASE = 3'd5;

    localparam logic [WORD_W-1:0] ALL_NEG = {LANES{8'h80}};
    localparam logic [WORD_W-1:0] ALL_POS = {LANES{8'h7F}};
    localparam logic [WORD_W-1:0] ALL_M1  = {LANES{8'hFF}};
    localparam logic [WORD_W-1:0] MIXED   = 64'h7F80_01FF_00FE_8101;

    class max_pool_board;
        cfg_t regs = '{stride: 4'd1, pad: 4'd0, in_height: 11'd1, in_width: 11'd1,
                       out_width_align8: 11'd8};
        bit [WORD_W-1:0] line_max [OUT_DEPTH][NUM_WORDS];
        out_item_t expected_maxima [$];
        int mismatches = 0;
        int checked = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_STRIDE:    regs.stride = val[3:0];
                CFG_PAD:       regs.pad = val[3:0];
                CFG_IN_HEIGHT: regs.in_height = val;
                CFG_IN_WIDTH:  regs.in_width = val;
                CFG_OUT_W8:    regs.out_width_align8 = val;
                default: ;
            endcase
        endfunction

        function int unsigned line_of(logic [7:0] dt, logic [9:0] oc);
            int unsigned a, b, c;
            a = dt;
            b = regs.out_width_align8;
            c = oc;
            return (a * b + c) % OUT_DEPTH;
        endfunction

        function logic [WORD_W-1:0] signed_byte_max(logic [WORD_W-1:0] x,
                                                     logic [WORD_W-1:0] y);
            logic [WORD_W-1:0] m;
            byte sx, sy;
            for (int k = 0; k < LANES; k++) begin
                sx = x[8*k +: 8];
                sy = y[8*k +: 8];
                m[8*k +: 8] = (sx > sy) ? sx : sy;
            end
            return m;
        endfunction

        function void note_tap(in_item_t t);
            int row, col, k, p, wr, wc, h, w;
            int unsigned addr;
            bit in_map, first_tap;
            logic [WORD_W-1:0] tap_w [NUM_WORDS];
            out_item_t e;
            k = regs.stride;
            p = regs.pad;
            h = regs.in_height;
            w = regs.in_width;
            wr = t.win_row;
            wc = t.win_col;
            row = t.out_row;
            col = t.out_col;
            row = row * k - p + wr;
            col = col * k - p + wc;
            in_map = row >= 0 && row < h && col >= 0 && col < w;
            first_tap = (wr == 0) && (wc == 0);
            addr = line_of(t.depth_tile, t.out_col);
            tap_w = '{t.bank0_low, t.bank0_high, t.bank1_low, t.bank1_high};
            for (int i = 0; i < NUM_WORDS; i++) begin
                line_max[addr][i] = signed_byte_max(in_map ? tap_w[i] : '0,
                                                    first_tap ? '0 : line_max[addr][i]);
            end
            e.result_addr = addr[RES_ADDR_W-1:0];
            e.max0_low    = line_max[addr][0];
            e.max0_high   = line_max[addr][1];
            e.max1_low    = line_max[addr][2];
            e.max1_high   = line_max[addr][3];
            expected_maxima.push_back(e);
        endfunction

        function int pending();
            return expected_maxima.size();
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= REPORT_CAP) $display("mismatch at %0t: %s", $time, msg);
        endtask

        task cmp_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
        endtask

        task check_maxima(out_item_t got);
            out_item_t want;
            if (expected_maxima.size() == 0) begin
                report($sformatf("result for line %0d with no request pending",
                                 got.result_addr));
                return;
            end
            want = expected_maxima.pop_front();
            checked++;
            cmp_field("result_addr", got.result_addr, want.result_addr);
            cmp_field("max0_low", got.max0_low, want.max0_low);
            cmp_field("max0_high", got.max0_high, want.max0_high);
            cmp_field("max1_low", got.max1_low, want.max1_low);
            cmp_field("max1_high", got.max1_high, want.max1_high);
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    max_pool_board board = new;
    bit touched [OUT_DEPTH];
    cfg_t sweep [$];
    int taps_sent = 0;
    int taps_taken = 0;
    int settings_used = 0;
    int burst_left = 0;
    int hold_left = 0;
    int holds_done = 0;
    int next_hold = 100;
    int pause_left = 0;
    int steady_left = 0;
    int roll;
    int cycle_count;

    padded_max_pool_window_update dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) board.check_maxima(m_data);
            if (s_valid && s_ready) begin
                board.note_tap(s_data);
                taps_taken++;
            end
            if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
        end
    end

    // result side: random stalls, steady stretches and long hold-offs
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (taps_taken >= next_hold && holds_done < MAX_HOLDS) begin
            m_ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            holds_done++;
            next_hold += HOLD_STEP;
        end else if (pause_left > 0) begin
            m_ready <= 1'b0;
            pause_left--;
        end else if (steady_left > 0) begin
            m_ready <= 1'b1;
            steady_left--;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                steady_left = $urandom_range(20, 80);
                m_ready <= 1'b1;
            end else if (roll < 70) begin
                m_ready <= 1'b1;
            end else if (roll < 96) begin
                pause_left = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                pause_left = $urandom_range(10, 40);
                m_ready <= 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [WORD_W-1:0] lane_word();
        case ($urandom_range(0, 9))
            0: return ALL_NEG;
            1: return ALL_POS;
            2: return ALL_M1;
            3: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic in_item_t with_banks(in_item_t it);
        it.bank0_low  = lane_word();
        it.bank0_high = lane_word();
        it.bank1_low  = lane_word();
        it.bank1_high = lane_word();
        return it;
    endfunction

    function automatic in_item_t tap_of(int orow, int dt, int ocol, int wr, int wc,
                                        logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
                                        logic [WORD_W-1:0] w2, logic [WORD_W-1:0] w3);
        in_item_t it;
        it.out_row    = 10'(orow);
        it.depth_tile = 8'(dt);
        it.out_col    = 10'(ocol);
        it.win_row    = 4'(wr);
        it.win_col    = 4'(wc);
        it.bank0_low  = w0;
        it.bank0_high = w1;
        it.bank1_low  = w2;
        it.bank1_high = w3;
        return it;
    endfunction

    function automatic cfg_t make_setting(int s, int p, int h, int w, int o);
        cfg_t c;
        c.stride = 4'(s);
        c.pad = 4'(p);
        c.in_height = 11'(h);
        c.in_width = 11'(w);
        c.out_width_align8 = 11'(o);
        return c;
    endfunction

    function automatic cfg_t random_setting();
        cfg_t c;
        c.stride = 4'($urandom_range(0, 15));
        c.pad = 4'($urandom_range(0, 15));
        c.in_height = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                                  : 11'($urandom_range(1, 64));
        c.in_width = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                                 : 11'($urandom_range(1, 64));
        c.out_width_align8 = ($urandom_range(0, 1) == 0) ? 11'(8 * $urandom_range(1, 128))
                                                         : 11'($urandom_range(0, 2047));
        return c;
    endfunction

    // output coordinate that mostly lands the window on the map
    function automatic logic [9:0] pick_coord(int span);
        int s, top;
        if ($urandom_range(0, 4) == 0) return 10'($urandom_range(0, 1023));
        s = (board.regs.stride == 0) ? 1 : board.regs.stride;
        top = (span + board.regs.pad) / s + 1;
        if (top > 1023) top = 1023;
        return 10'($urandom_range(0, top));
    endfunction

    task automatic send_tap(input in_item_t it);
        int gap;
        int unsigned a;
        a = board.line_of(it.depth_tile, it.out_col);
        // a line never written must start with the first tap of a window
        if (!touched[a]) begin
            it.win_row = '0;
            it.win_col = '0;
        end
        touched[a] = 1'b1;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        taps_sent++;
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apply_setting(input cfg_t c);
        logic [CFG_DATA_W-1:0] hi;
        hi = CFG_DATA_W'($urandom_range(0, 2047));
        put_reg(CFG_IDX_W'(REG_SPARE_BASE + $urandom_range(0, 2)), hi);
        hi = CFG_DATA_W'($urandom_range(0, 2047));
        put_reg(CFG_STRIDE, {hi[CFG_DATA_W-1:4], c.stride});
        hi = CFG_DATA_W'($urandom_range(0, 2047));
        put_reg(CFG_PAD, {hi[CFG_DATA_W-1:4], c.pad});
        put_reg(CFG_IN_HEIGHT, c.in_height);
        put_reg(CFG_IN_WIDTH, c.in_width);
        put_reg(CFG_OUT_W8, c.out_width_align8);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic close_phase();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic send_window();
        in_item_t it;
        int rows, cols, stop_at, n;
        it.out_row = pick_coord(board.regs.in_height);
        it.out_col = pick_coord(board.regs.in_width);
        it.depth_tile = 8'($urandom_range(0, 255));
        rows = $urandom_range(1, 4);
        cols = $urandom_range(1, 4);
        // some windows are cut short
        stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, rows * cols) : rows * cols;
        n = 0;
        for (int r = 0; r < rows && n < stop_at; r++) begin
            for (int c = 0; c < cols && n < stop_at; c++) begin
                it.win_row = 4'(r);
                it.win_col = 4'(c);
                send_tap(with_banks(it));
                n++;
            end
        end
    endtask

    task automatic send_noise();
        in_item_t it;
        it.out_row = 10'($urandom_range(0, 1023));
        it.depth_tile = 8'($urandom_range(0, 255));
        it.out_col = 10'($urandom_range(0, 1023));
        it.win_row = 4'($urandom_range(0, 15));
        it.win_col = 4'($urandom_range(0, 15));
        send_tap(with_banks(it));
    endtask

    task automatic run_random(input int n);
        int stop_at;
        stop_at = taps_sent + n;
        while (taps_sent < stop_at) begin
            if ($urandom_range(0, 5) == 0) send_noise();
            else send_window();
        end
    endtask

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge aclk);
        $display("timeout with %0d results outstanding", board.pending());
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: only tap (0,0) of the map is inside
        send_tap(tap_of(0, 0, 0, 0, 0, MIXED, ALL_M1, ALL_NEG, ALL_POS));
        send_tap(tap_of(0, 0, 0, 0, 1, ALL_POS, ALL_POS, ALL_POS, ALL_POS));
        send_tap(tap_of(0, 0, 0, 1, 0, ALL_POS, ALL_M1, ALL_POS, ALL_M1));
        send_tap(tap_of(1023, 255, 1023, 0, 0, ALL_M1, ALL_M1, ALL_M1, ALL_M1));
        send_tap(tap_of(1023, 255, 1023, 15, 15, ALL_POS, ALL_NEG, MIXED, ALL_POS));
        close_phase();

        // padded map of 7x7 with stride 3
        apply_setting(make_setting(3, 2, 7, 7, 8));
        send_tap(tap_of(0, 1, 0, 0, 0, ALL_POS, ALL_POS, ALL_POS, ALL_POS));
        send_tap(tap_of(0, 1, 0, 2, 2, ALL_NEG, ALL_POS, MIXED, lane_word()));
        send_tap(tap_of(0, 1, 0, 1, 2, ALL_POS, ALL_POS, ALL_POS, ALL_POS));
        send_tap(tap_of(0, 1, 0, 2, 1, ALL_POS, ALL_POS, ALL_POS, ALL_POS));
        send_tap(tap_of(2, 3, 2, 0, 0, MIXED, ALL_NEG, ALL_M1, lane_word()));
        send_tap(tap_of(2, 3, 2, 2, 2, lane_word(), lane_word(), lane_word(), lane_word()));
        send_tap(tap_of(2, 3, 2, 3, 2, ALL_POS, ALL_POS, ALL_POS, ALL_POS));
        send_tap(tap_of(2, 3, 2, 2, 3, ALL_POS, ALL_POS, ALL_POS, ALL_POS));
        send_tap(tap_of(2, 3, 2, 1, 1, ALL_POS, ALL_POS, ALL_POS, ALL_POS));
        send_tap(tap_of(2, 3, 2, 0, 0, ALL_NEG, ALL_NEG, ALL_NEG, ALL_NEG));
        send_tap(tap_of(5, 200, 100, 0, 0, lane_word(), MIXED, ALL_POS, ALL_M1));
        send_tap(tap_of(5, 200, 100, 15, 0, ALL_POS, ALL_POS, ALL_POS, ALL_POS));
        close_phase();

        sweep.push_back(make_setting(1, 0, 1, 1, 8));
        sweep.push_back(make_setting(15, 15, 2047, 2047, 2047));
        sweep.push_back(make_setting(0, 5, 0, 30, 0));
        sweep.push_back(make_setting(2, 1, 48, 48, 24));
        sweep.push_back(make_setting(3, 1, 50, 0, 100));
        sweep.push_back(make_setting(1, 0, 1024, 1024, 1024));
        repeat (2) sweep.push_back(random_setting());
        foreach (sweep[i]) begin
            apply_setting(sweep[i]);
            run_random(PHASE_TAPS);
            close_phase();
        end

        $display("%0d taps sent under %0d register settings, %0d results checked",
                 taps_taken, settings_used, board.checked);
        $display("result side held off %0d times for %0d cycles, %0d mismatches",
                 holds_done, HOLD_CYCLES, board.mismatches);
        if (board.mismatches == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
